// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file.
// Both expect signals named clk and rst in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define R1MU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define R1MU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/r1mu_pkg.sv =====
`default_nettype none

package r1mu_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int X_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int Y_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  localparam int Q_W = 32;

  // Request codes
  localparam logic [1:0] REQ_LOAD_X = 2'd0;
  localparam logic [1:0] REQ_LOAD_Y = 2'd1;
  localparam logic [1:0] REQ_MATRIX = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_ALPHA     = 2'd0;
  localparam logic [1:0] CFG_ROW_COUNT = 2'd1;
  localparam logic [1:0] CFG_COL_COUNT = 2'd2;

  localparam logic signed [31:0] ALPHA_RESET     = 32'sd65536;
  localparam logic [6:0]          ROW_COUNT_RESET = 7'd64;
  localparam logic [6:0]          COL_COUNT_RESET = 7'd64;

  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] value;
  } req_item_t;

  typedef struct packed {
    logic [5:0]         out_row;
    logic [5:0]         out_col;
    logic signed [31:0] out_value;
    logic               saturated;
  } rsp_item_t;

  typedef struct packed {
    logic               clipped;
    logic signed [31:0] value;
  } sat_t;

  // Full signed 32x32 product
  function automatic logic signed [63:0] mul_q(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] a64;
    logic signed [63:0] b64;
    a64 = 64'(a);
    b64 = 64'(b);
    return a64 * b64;
  endfunction

  // Clip a 49-bit signed value to the Q16.16 range
  function automatic sat_t sat_q(input logic signed [48:0] v);
    sat_t r;
    r.clipped = (v[48:31] != {18{v[48]}});
    if (r.clipped) begin
      r.value = v[48] ? Q_MIN : Q_MAX;
    end else begin
      r.value = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/r1mu_ram.sv =====
`default_nettype none

module r1mu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rank_one_matrix_update_unit.sv =====
// A matrix element passes in registered steps through memory read, alpha*y, clip, x*t,
// and add and clip into the output register. Throughput: one request per cycle unless
// responses stall, loads and matrix elements alike; the vector stores are single-port-write
// memories read once per matrix element, which sets that rate.
// Reset: clears alpha to 1.0, both counts to 64 and every pipeline valid bit; the
// vector stores are not cleared and must be loaded before use.
`default_nettype none

module rank_one_matrix_update_unit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Request channel
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire r1mu_pkg::req_item_t  req,
  // Response channel
  output logic                      rsp_valid,
  input  wire logic                 rsp_ready,
  output r1mu_pkg::rsp_item_t       rsp,
  // Configuration writes
  input  wire logic                 cfg_write,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [31:0]          cfg_data
);

  // Per-element data that travels alongside the arithmetic
  typedef struct packed {
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] a;
    logic               region;
  } meta_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [31:0] alpha;
  logic [6:0]         row_count;
  logic [6:0]         col_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha     <= r1mu_pkg::ALPHA_RESET;
      row_count <= r1mu_pkg::ROW_COUNT_RESET;
      col_count <= r1mu_pkg::COL_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        r1mu_pkg::CFG_ALPHA:     alpha     <= cfg_data;
        r1mu_pkg::CFG_ROW_COUNT: row_count <= cfg_data[6:0];
        r1mu_pkg::CFG_COL_COUNT: col_count <= cfg_data[6:0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage enables. Each stage loads when it is empty or its successor loads,
  // so bubbles close up and a full pipe stalls only while the output register
  // waits for the response to be taken.
  // ---------------------------------------------------------------------------
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5 || rsp_ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign req_ready = en1;

  // ---------------------------------------------------------------------------
  // Request decode and vector stores
  // ---------------------------------------------------------------------------
  logic                     req_xfer;
  logic                     x_we;
  logic                     y_we;
  logic                     row_ok;
  logic                     col_ok;
  logic [r1mu_pkg::X_AW-1:0] x_addr;
  logic [r1mu_pkg::Y_AW-1:0] y_addr;
  logic [31:0]              x_q;
  logic [31:0]              y_q;

  assign req_xfer = req_valid && req_ready;
  assign row_ok   = 32'(req.row) < r1mu_pkg::MAX_ROWS;
  assign col_ok   = 32'(req.col) < r1mu_pkg::MAX_COLS;
  assign x_addr   = r1mu_pkg::X_AW'(req.row);
  assign y_addr   = r1mu_pkg::Y_AW'(req.col);

  // Loads out of range are dropped. A matrix element reads both stores in the
  // cycle of its transfer; a load in the previous cycle has already landed, so
  // no forwarding is needed.
  assign x_we = req_xfer && (req.req_type == r1mu_pkg::REQ_LOAD_X) && row_ok;
  assign y_we = req_xfer && (req.req_type == r1mu_pkg::REQ_LOAD_Y) && col_ok;

  r1mu_ram #(
    .WIDTH (r1mu_pkg::Q_W),
    .DEPTH (r1mu_pkg::MAX_ROWS)
  ) u_x_store (
    .clk     (clk),
    .wr_en   (x_we),
    .wr_addr (x_addr),
    .wr_data (req.value),
    .rd_en   (en1),
    .rd_addr (x_addr),
    .rd_data (x_q)
  );

  r1mu_ram #(
    .WIDTH (r1mu_pkg::Q_W),
    .DEPTH (r1mu_pkg::MAX_COLS)
  ) u_y_store (
    .clk     (clk),
    .wr_en   (y_we),
    .wr_addr (y_addr),
    .wr_data (req.value),
    .rd_en   (en1),
    .rd_addr (y_addr),
    .rd_data (y_q)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: store read in flight; hold the element and its region test
  // ---------------------------------------------------------------------------
  meta_t m1, m2, m3, m4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= req_xfer && (req.req_type == r1mu_pkg::REQ_MATRIX);
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      m1.row    <= req.row;
      m1.col    <= req.col;
      m1.a      <= req.value;
      // Counts above the store depth behave as the full depth
      m1.region <= ({1'b0, req.row} < row_count) && ({1'b0, req.col} < col_count) &&
                   row_ok && col_ok;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: alpha * y[col]
  // ---------------------------------------------------------------------------
  logic signed [63:0] ay;
  logic signed [31:0] x2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      m2 <= m1;
      x2 <= x_q;
      ay <= r1mu_pkg::mul_q(alpha, $signed(y_q));
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: truncate to Q16.16 (floor) and clip t
  // ---------------------------------------------------------------------------
  logic signed [47:0] t_wide;
  r1mu_pkg::sat_t     t_sat;
  logic signed [31:0] t3;
  logic               tc3;
  logic signed [31:0] x3;

  assign t_wide = ay[63:16];
  assign t_sat  = r1mu_pkg::sat_q(49'(t_wide));

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      m3  <= m2;
      x3  <= x2;
      t3  <= t_sat.value;
      tc3 <= t_sat.clipped;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: x[row] * t
  // ---------------------------------------------------------------------------
  logic signed [63:0] xt;
  logic               tc4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      m4  <= m3;
      tc4 <= tc3;
      xt  <= r1mu_pkg::mul_q(x3, t3);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: a + floor(x*t), clip, and hold in the output register until taken.
  // Elements outside the region pass through unchanged and unflagged.
  // ---------------------------------------------------------------------------
  logic signed [47:0] p_wide;
  logic signed [48:0] sum;
  r1mu_pkg::sat_t     sum_sat;

  assign p_wide  = xt[63:16];
  assign sum     = 49'(m4.a) + 49'(p_wide);
  assign sum_sat = r1mu_pkg::sat_q(sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en5) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      rsp.out_row   <= m4.row;
      rsp.out_col   <= m4.col;
      rsp.out_value <= m4.region ? sum_sat.value : m4.a;
      rsp.saturated <= m4.region && (tc4 || sum_sat.clipped);
    end
  end

  assign rsp_valid = v5;

endmodule

`default_nettype wire

// ===== rtl/r1mu_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module r1mu_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                req_ready,
  input wire logic                rsp_valid,
  input wire logic                rsp_ready,
  input wire r1mu_pkg::rsp_item_t rsp
);

  // A stalled response holds its payload
  `R1MU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response changed while stalled")

  // An empty output register means the whole pipe can move
  `R1MU_ASSERT_SAME(a_ready_when_empty, !rsp_valid, req_ready, "request refused with output empty")

  // A response leaving frees room for a new request in the same cycle
  `R1MU_ASSERT_SAME(a_ready_on_drain, rsp_valid && rsp_ready, req_ready, "request refused while output drains")

  // Nothing comes out in the cycle after reset
  `R1MU_ASSERT_SAME(a_quiet_after_reset, $past(rst), !rsp_valid, "response valid right after reset")

endmodule

bind rank_one_matrix_update_unit r1mu_checker u_r1mu_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire

// ===== tb/sv/tb_rank_one_matrix_update_unit.sv =====
`default_nettype none

module tb_rank_one_matrix_update_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import r1mu_pkg::*;

  // Request code and register index that the block must ignore
  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  // Pipeline depth is 5; leave a little margin before touching registers
  localparam int SETTLE_CYCLES = 8;
  // Cycles with no transfer on either channel before the run is abandoned
  localparam int STALL_LIMIT = 2000;
  localparam int IDLE_PCT = 33;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        req_valid = 1'b0;
  logic        req_ready;
  req_item_t   req = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rsp_item_t   rsp;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  rank_one_matrix_update_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Requests waiting for the driver, and updates waiting for the block
  req_item_t pending_reqs[$];
  rsp_item_t expected_updates[$];

  // Shadow of the block as seen at transfer time: registers and vector stores
  logic signed [31:0] alpha_q = ALPHA_RESET;
  logic [6:0]         row_lim = ROW_COUNT_RESET;
  logic [6:0]         col_lim = COL_COUNT_RESET;
  logic signed [31:0] x_vec [MAX_ROWS];
  logic signed [31:0] y_vec [MAX_COLS];

  // Generator's view: which store entries are loaded, and the region in force
  bit         gen_x_loaded [MAX_ROWS];
  bit         gen_y_loaded [MAX_COLS];
  logic [6:0] gen_rows = ROW_COUNT_RESET;
  logic [6:0] gen_cols = COL_COUNT_RESET;

  int unsigned send_idle_pct = IDLE_PCT;
  int unsigned recv_idle_pct = IDLE_PCT;

  bit        req_accepted = 1'b0;
  int        mismatches = 0;
  int        n_requests = 0;
  int        n_checked = 0;
  int        n_settings = 0;
  int        stall_cycles = 0;
  rsp_item_t want;

  // Work out one updated element: t = alpha*y, p = x*t, then a + p.
  // Each product drops its 16 low bits (floor); t and the sum saturate.
  function automatic rsp_item_t updated_element(req_item_t it);
    rsp_item_t          r;
    logic signed [63:0] a_w;
    logic signed [63:0] t_w;
    logic signed [63:0] p_w;
    logic signed [63:0] s_w;
    r.out_row   = it.row;
    r.out_col   = it.col;
    r.out_value = it.value;
    r.saturated = 1'b0;
    if (it.row < row_lim && it.col < col_lim) begin
      a_w = it.value;
      t_w = alpha_q;
      p_w = y_vec[it.col];
      t_w = (t_w * p_w) >>> 16;
      if (t_w > Q_MAX) begin
        t_w = Q_MAX;
        r.saturated = 1'b1;
      end else if (t_w < Q_MIN) begin
        t_w = Q_MIN;
        r.saturated = 1'b1;
      end
      p_w = x_vec[it.row];
      p_w = (p_w * t_w) >>> 16;
      s_w = a_w + p_w;
      if (s_w > Q_MAX) begin
        s_w = Q_MAX;
        r.saturated = 1'b1;
      end else if (s_w < Q_MIN) begin
        s_w = Q_MIN;
        r.saturated = 1'b1;
      end
      r.out_value = s_w[31:0];
    end
    return r;
  endfunction

  // Driver: change inputs on the falling edge. Hold the payload until the
  // transfer seen at the last rising edge, then advance or drop valid.
  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_accepted) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req       <= pending_reqs.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Monitor: sample on the rising edge. Request transfers update the shadow
  // stores or queue an expected update; response transfers are checked
  // against the oldest expectation; register writes update the shadow.
  always @(posedge clk) begin
    req_accepted <= req_valid && req_ready && !rst;
    if (!rst) begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_ALPHA:     alpha_q = cfg_data;
          CFG_ROW_COUNT: row_lim = cfg_data[6:0];
          CFG_COL_COUNT: col_lim = cfg_data[6:0];
          default: ;
        endcase
      end
      if (req_valid && req_ready) begin
        n_requests++;
        case (req.req_type)
          REQ_LOAD_X: x_vec[req.row] = req.value;
          REQ_LOAD_Y: y_vec[req.col] = req.value;
          REQ_MATRIX: expected_updates.push_back(updated_element(req));
          default: ;
        endcase
      end
      if (rsp_valid && rsp_ready) begin
        if (expected_updates.size() == 0) begin
          $error("result with no update pending: row %0d col %0d value %0d",
                 rsp.out_row, rsp.out_col, rsp.out_value);
          mismatches++;
        end else begin
          want = expected_updates.pop_front();
          n_checked++;
          if (rsp.out_row !== want.out_row) begin
            $error("out_row: expected %0d, got %0d", want.out_row, rsp.out_row);
            mismatches++;
          end
          if (rsp.out_col !== want.out_col) begin
            $error("out_col: expected %0d, got %0d", want.out_col, rsp.out_col);
            mismatches++;
          end
          if (rsp.out_value !== want.out_value) begin
            $error("out_value: expected %0d, got %0d", want.out_value, rsp.out_value);
            mismatches++;
          end
          if (rsp.saturated !== want.saturated) begin
            $error("saturated: expected %0d, got %0d", want.saturated, rsp.saturated);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: abandon the run if neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Mostly full-range values, with the extremes, values within plus or minus one and values near zero
  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(7))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return 32'(int'($urandom_range(131072)) - 65536);
      3: return 32'(int'($urandom_range(255)) - 128);
      default: return $urandom();
    endcase
  endfunction

  task automatic add_load_x(input logic [5:0] idx, input logic signed [31:0] val);
    pending_reqs.push_back('{REQ_LOAD_X, idx, 6'($urandom_range(63)), val});
    gen_x_loaded[idx] = 1'b1;
  endtask

  task automatic add_load_y(input logic [5:0] idx, input logic signed [31:0] val);
    pending_reqs.push_back('{REQ_LOAD_Y, 6'($urandom_range(63)), idx, val});
    gen_y_loaded[idx] = 1'b1;
  endtask

  // Queue a matrix element; inside the region, load any store entry it
  // reads that has never been written
  task automatic add_matrix(input logic [5:0] r, input logic [5:0] c,
                            input logic signed [31:0] val);
    if (r < gen_rows && c < gen_cols) begin
      if (!gen_x_loaded[r]) add_load_x(r, rand_q());
      if (!gen_y_loaded[c]) add_load_y(c, rand_q());
    end
    pending_reqs.push_back('{REQ_MATRIX, r, c, val});
  endtask

  task automatic add_spare();
    pending_reqs.push_back('{REQ_SPARE, 6'($urandom_range(63)), 6'($urandom_range(63)),
                             32'($urandom())});
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Counts go out with random upper bits, which the block must drop
  task automatic set_config(input logic signed [31:0] alpha, input logic [6:0] rows,
                            input logic [6:0] cols);
    logic [31:0] data;
    write_reg(CFG_ALPHA, alpha);
    data = $urandom();
    data[6:0] = rows;
    write_reg(CFG_ROW_COUNT, data);
    data = $urandom();
    data[6:0] = cols;
    write_reg(CFG_COL_COUNT, data);
    gen_rows = rows;
    gen_cols = cols;
    n_settings++;
  endtask

  // Wait for every request to go in and every update to come out, then let
  // the pipeline settle so that trailing loads have landed
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pending_reqs.size() != 0 || req_valid || expected_updates.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random traffic: loads, matrix elements and the odd ignored request;
  // ignored requests do not count towards the total
  task automatic add_random(input int count);
    int made;
    made = 0;
    while (made < count) begin
      case ($urandom_range(19))
        0, 1, 2, 3: add_load_x(6'($urandom_range(63)), rand_q());
        4, 5, 6, 7: add_load_y(6'($urandom_range(63)), rand_q());
        8:          add_spare();
        default:    add_matrix(6'($urandom_range(63)), 6'($urandom_range(63)), rand_q());
      endcase
      if (pending_reqs.size() != 0 && pending_reqs[$].req_type != REQ_SPARE) made++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, reset settings (alpha 1.0, full 64 by 64 region):
    // extreme store contents driving the sum into both clip limits
    add_load_x(6'd0, Q_MAX);
    add_load_y(6'd0, Q_MAX);
    add_load_x(6'd63, Q_MIN);
    add_load_y(6'd63, Q_MIN);
    add_matrix(6'd0, 6'd0, Q_MAX);
    add_matrix(6'd63, 6'd63, Q_MIN);
    add_matrix(6'd0, 6'd63, Q_MIN);
    add_load_x(6'd1, 32'sd65536);
    add_load_y(6'd1, -32'sd65536);
    add_matrix(6'd1, 6'd1, 32'sd0);
    add_matrix(6'd1, 6'd1, Q_MIN);
    add_matrix(6'd1, 6'd0, 32'sd12345);
    add_spare();
    drain();

    // Largest alpha: t clips while the sum stays in range; row 5 lies
    // outside a two-row region; an oversize column count acts as 64
    set_config(Q_MAX, 7'd2, 7'd127);
    add_load_x(6'd1, 32'sd1);
    add_matrix(6'd1, 6'd0, 32'sd0);
    add_matrix(6'd5, 6'd0, Q_MAX);
    add_matrix(6'd0, 6'd63, -32'sd1);
    drain();

    // Empty region: everything passes through
    set_config(Q_MIN, 7'd0, 7'd0);
    add_matrix(6'd0, 6'd0, Q_MIN);
    add_matrix(6'd63, 6'd63, -32'sd1);
    drain();

    // Random phases across a spread of settings
    set_config(rand_q(), 7'd64, 7'd64);
    write_reg(CFG_SPARE, $urandom());
    add_random(170);
    drain();

    set_config(Q_MIN, 7'd0, 7'd64);
    add_random(170);
    drain();

    set_config(Q_MAX, 7'd127, 7'd1);
    add_random(170);
    drain();

    // Hold the sender off midway until every update has come back
    set_config(32'(int'($urandom_range(262144)) - 131072),
               7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)));
    add_random(85);
    drain();
    add_random(85);
    drain();

    set_config(32'sd0, 7'd100, 7'd127);
    add_random(170);
    drain();

    // Back-to-back stretch: no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(ALPHA_RESET, 7'd64, 7'd64);
    add_random(170);
    drain();
    send_idle_pct = IDLE_PCT;
    recv_idle_pct = IDLE_PCT;

    set_config($urandom(), 7'($urandom_range(127)), 7'($urandom_range(127)));
    add_random(170);
    drain();

    $display("Covered %0d request transfers and %0d checked updates", n_requests, n_checked);
    $display("across %0d register settings, from empty to oversize regions", n_settings);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
